// File: sv/poi_pkg.sv
// ----------------------------------------------------------------------------
// poi_pkg
// shared constants, codes and arithmetic helpers of the odometry integrator
// ----------------------------------------------------------------------------
package poi_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int STAGE_LIMIT   = 30;
   localparam int STAGE_COUNT   = (CORDIC_STAGES > STAGE_LIMIT) ? STAGE_LIMIT : CORDIC_STAGES;
   localparam int CNT_W         = $clog2(STAGE_COUNT);

   localparam logic signed [33:0] CORDIC_X0   = 34'sd652032874;
   localparam logic        [29:0] TURN_TO_BAM = 30'd683565276;

   localparam logic REQ_VELOCITY = 1'b0;
   localparam logic REQ_TICK     = 1'b1;

   localparam logic [7:0] CSR_GAIN_LINEAR  = 8'd0;
   localparam logic [7:0] CSR_GAIN_ANGULAR = 8'd1;

   typedef logic signed [32:0] mul_op_type;
   typedef logic signed [65:0] mul_prod_type;
   typedef logic signed [33:0] cordic_val_type;

   // atan(2^-i) as a binary angle
   function automatic logic [29:0] atan_bam(input logic [4:0] i);
      case (i)
         5'd0:  atan_bam = 30'd536870912;
         5'd1:  atan_bam = 30'd316933406;
         5'd2:  atan_bam = 30'd167458907;
         5'd3:  atan_bam = 30'd85004756;
         5'd4:  atan_bam = 30'd42667331;
         5'd5:  atan_bam = 30'd21354465;
         5'd6:  atan_bam = 30'd10679838;
         5'd7:  atan_bam = 30'd5340245;
         5'd8:  atan_bam = 30'd2670163;
         5'd9:  atan_bam = 30'd1335087;
         5'd10: atan_bam = 30'd667544;
         5'd11: atan_bam = 30'd333772;
         5'd12: atan_bam = 30'd166886;
         5'd13: atan_bam = 30'd83443;
         5'd14: atan_bam = 30'd41722;
         5'd15: atan_bam = 30'd20861;
         5'd16: atan_bam = 30'd10430;
         5'd17: atan_bam = 30'd5215;
         5'd18: atan_bam = 30'd2608;
         5'd19: atan_bam = 30'd1304;
         5'd20: atan_bam = 30'd652;
         5'd21: atan_bam = 30'd326;
         5'd22: atan_bam = 30'd163;
         5'd23: atan_bam = 30'd81;
         5'd24: atan_bam = 30'd41;
         5'd25: atan_bam = 30'd20;
         5'd26: atan_bam = 30'd10;
         5'd27: atan_bam = 30'd5;
         5'd28: atan_bam = 30'd3;
         5'd29: atan_bam = 30'd1;
         default: atan_bam = 30'd0;
      endcase
   endfunction

   // saturate a wide signed value to 32 bits
   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647)
         sat32 = 32'h7fff_ffff;
      else if (v < -66'sd2147483648)
         sat32 = 32'h8000_0000;
      else
         sat32 = v[31:0];
   endfunction

   // q2.30 to q1.15, round half up, saturate
   function automatic logic [15:0] q15(input logic signed [33:0] v);
      logic signed [33:0] t;
      logic signed [33:0] r;
      t = v + 34'sd16384;
      r = t >>> 15;
      if (r > 34'sd32767)
         q15 = 16'h7fff;
      else if (r < -34'sd32768)
         q15 = 16'h8000;
      else
         q15 = r[15:0];
   endfunction

endpackage

// File: sv/poi_if.sv
// ----------------------------------------------------------------------------
// poi_if
// valid/ready channels of the odometry integrator
// ----------------------------------------------------------------------------
interface poi_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] lin_speed;
   logic [31:0] ang_speed;
   logic [15:0] elapsed;
   modport source (output valid, req_type, lin_speed, ang_speed, elapsed, input ready);
   modport sink   (input valid, req_type, lin_speed, ang_speed, elapsed, output ready);
endinterface

interface poi_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] heading;
   logic [15:0] quat_z;
   logic [15:0] quat_w;
   logic [31:0] vel_lin;
   logic [31:0] vel_ang;
   modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w, vel_lin, vel_ang,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, heading, quat_z, quat_w, vel_lin, vel_ang,
                   output ready);
endinterface

interface poi_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/poi_mul.sv
// ----------------------------------------------------------------------------
// poi_mul
// shared signed 33x33 multiplier with registered product
// ----------------------------------------------------------------------------
module poi_mul (
   input  logic                  clock,
   input  poi_pkg::mul_op_type   op_a,
   input  poi_pkg::mul_op_type   op_b,
   output poi_pkg::mul_prod_type prod
);
   import poi_pkg::*;

   mul_prod_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// File: sv/poi_cordic.sv
// ----------------------------------------------------------------------------
// poi_cordic
// rotation-mode cordic, one iteration per cycle
// ----------------------------------------------------------------------------
module poi_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             angle,
   output logic                    busy,
   output poi_pkg::cordic_val_type cos_out,
   output poi_pkg::cordic_val_type sin_out
);
   import poi_pkg::*;

   logic               run_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               flip_ff;
   cordic_val_type     x_ff, y_ff, z_ff;
   logic [1:0]         top;
   logic [31:0]        folded;
   cordic_val_type     dx, dy, step;

   assign top    = angle[31:30];
   assign folded = (top == 2'd1 || top == 2'd2) ? angle + 32'h8000_0000 : angle;
   assign dx     = y_ff >>> cnt_ff;
   assign dy     = x_ff >>> cnt_ff;
   assign step   = $signed({4'b0, atan_bam(5'(cnt_ff))});

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         cnt_ff  <= '0;
         flip_ff <= (top == 2'd1 || top == 2'd2);
         x_ff    <= CORDIC_X0;
         y_ff    <= '0;
         z_ff    <= $signed({{2{folded[31]}}, folded});
      end else if (run_ff) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - step;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + step;
         end
         if (cnt_ff == CNT_W'(STAGE_COUNT - 1))
            run_ff <= 1'b0;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign busy    = run_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

// File: sv/planar_odometry_integrator.sv
// ----------------------------------------------------------------------------
// planar_odometry_integrator
// dead-reckoning odometry for a differential drive base
// ----------------------------------------------------------------------------
// channels: req_ch takes items, rsp_ch gives the pose, csr_ch writes gains
//   req_type 0 is a velocity item: speeds are scaled by the q8.8 gains and
//   stored, no result item follows
//   req_type 1 is a tick item: x and y advance along the old heading, the
//   heading advances by turn rate times elapsed, one result item follows
// a tick makes two passes of the one-iteration-per-cycle cordic and six
//   passes through the one shared registered multiplier; the next item is
//   taken once the sequencer is back in idle
// one item at a time: req_ch.ready is high only while the sequencer idles
// the result sits in an output register, so a new item is taken while the
//   receiver stalls; a second tick then waits at its end for rsp_ch.ready
// csr_ch is always ready; writes to indexes other than 0 and 1 are dropped
// reset: gains return to 1.0, velocities, position and heading to zero,
//   no result pending
// ----------------------------------------------------------------------------
module planar_odometry_integrator (
   input  logic      clock,
   input  logic      reset,
   poi_req_if.sink   req_ch,
   poi_rsp_if.source rsp_ch,
   poi_csr_if.sink   csr_ch
);
   import poi_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_VEL_L, S_VEL_A, S_VEL_END, S_DIST, S_DSTORE, S_CORD1, S_MUL_C,
      S_MUL_S, S_TURN, S_K_LO, S_K_HI, S_YAW, S_QSTART, S_CORD2, S_OUT
   } state_type;

   state_type    state_ff;
   logic [15:0]  gain_lin_ff, gain_ang_ff;
   logic [31:0]  speed_ff, turn_ff, x_ff, y_ff, yaw_ff;
   logic [31:0]  ls_ff, as_ff;
   logic [15:0]  dt_ff;
   logic [31:0]  d_ff;
   logic [15:0]  ph_ff;
   logic [31:0]  hi_ff;

   logic         rsp_valid_ff;
   logic [31:0]  pos_x_ff, pos_y_ff, heading_ff, vel_lin_ff, vel_ang_ff;
   logic [15:0]  quat_z_ff, quat_w_ff;

   mul_op_type     mul_a, mul_b;
   mul_prod_type   prod;
   mul_prod_type   prod_q8, prod_q16, prod_q30;
   logic           cord_start, cord_busy;
   logic [31:0]    cord_angle;
   cordic_val_type cord_cos, cord_sin;
   logic           req_take, rsp_free;

   assign req_take = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign prod_q8  = prod >>> 8;
   assign prod_q16 = prod >>> 16;
   assign prod_q30 = prod >>> 30;

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_VEL_L: begin
            mul_a = $signed({ls_ff[31], ls_ff});
            mul_b = $signed({{17{gain_lin_ff[15]}}, gain_lin_ff});
         end
         S_VEL_A: begin
            mul_a = $signed({as_ff[31], as_ff});
            mul_b = $signed({{17{gain_ang_ff[15]}}, gain_ang_ff});
         end
         S_DIST: begin
            mul_a = $signed({speed_ff[31], speed_ff});
            mul_b = $signed({17'b0, dt_ff});
         end
         S_MUL_C: begin
            mul_a = $signed({d_ff[31], d_ff});
            mul_b = cord_cos[32:0];
         end
         S_MUL_S: begin
            mul_a = $signed({d_ff[31], d_ff});
            mul_b = cord_sin[32:0];
         end
         S_TURN: begin
            mul_a = $signed({turn_ff[31], turn_ff});
            mul_b = $signed({17'b0, dt_ff});
         end
         // low 32 bits of turn*dt, taken unsigned
         S_K_LO: begin
            mul_a = $signed({1'b0, prod[31:0]});
            mul_b = $signed({3'b0, TURN_TO_BAM});
         end
         // signed upper part of turn*dt
         S_K_HI: begin
            mul_a = $signed({{17{ph_ff[15]}}, ph_ff});
            mul_b = $signed({3'b0, TURN_TO_BAM});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign cord_start = (state_ff == S_DSTORE) || (state_ff == S_QSTART);
   assign cord_angle = (state_ff == S_QSTART) ? {1'b0, yaw_ff[31:1]} : yaw_ff;

   poi_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   poi_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .angle   (cord_angle),
      .busy    (cord_busy),
      .cos_out (cord_cos),
      .sin_out (cord_sin)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gain_lin_ff  <= 16'd256;
         gain_ang_ff  <= 16'd256;
         speed_ff     <= '0;
         turn_ff      <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         yaw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // gain writes; the user must issue them only while idle, the block itself does not enforce it
         if (csr_ch.valid) begin
            if (csr_ch.index == CSR_GAIN_LINEAR)
               gain_lin_ff <= csr_ch.data;
            else if (csr_ch.index == CSR_GAIN_ANGULAR)
               gain_ang_ff <= csr_ch.data;
         end

         // released once taken, unless the output step loads the next one
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_OUT)
            rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  ls_ff <= req_ch.lin_speed;
                  as_ff <= req_ch.ang_speed;
                  dt_ff <= req_ch.elapsed;
                  state_ff <= (req_ch.req_type == REQ_TICK) ? S_DIST : S_VEL_L;
               end
            end
            S_VEL_L:   state_ff <= S_VEL_A;
            S_VEL_A: begin
               speed_ff <= sat32(prod_q8);
               state_ff <= S_VEL_END;
            end
            S_VEL_END: begin
               turn_ff  <= sat32(prod_q8);
               state_ff <= S_IDLE;
            end
            S_DIST:    state_ff <= S_DSTORE;
            // distance in q16.16, cordic starts on the old heading
            S_DSTORE: begin
               d_ff     <= prod_q16[31:0];
               state_ff <= S_CORD1;
            end
            S_CORD1: begin
               if (!cord_busy)
                  state_ff <= S_MUL_C;
            end
            S_MUL_C:   state_ff <= S_MUL_S;
            S_MUL_S: begin
               x_ff     <= sat32(prod_q30 + $signed({{34{x_ff[31]}}, x_ff}));
               state_ff <= S_TURN;
            end
            S_TURN: begin
               y_ff     <= sat32(prod_q30 + $signed({{34{y_ff[31]}}, y_ff}));
               state_ff <= S_K_LO;
            end
            S_K_LO: begin
               ph_ff    <= prod[47:32];
               state_ff <= S_K_HI;
            end
            S_K_HI: begin
               hi_ff    <= prod[63:32];
               state_ff <= S_YAW;
            end
            // heading wraps mod 2^32
            S_YAW: begin
               yaw_ff   <= yaw_ff + prod[31:0] + hi_ff;
               state_ff <= S_QSTART;
            end
            S_QSTART:  state_ff <= S_CORD2;
            S_CORD2: begin
               if (!cord_busy)
                  state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  pos_x_ff     <= x_ff;
                  pos_y_ff     <= y_ff;
                  heading_ff   <= yaw_ff;
                  quat_z_ff    <= q15(cord_sin);
                  quat_w_ff    <= q15(cord_cos);
                  vel_lin_ff   <= speed_ff;
                  vel_ang_ff   <= turn_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default:   state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.pos_x   = pos_x_ff;
   assign rsp_ch.pos_y   = pos_y_ff;
   assign rsp_ch.heading = heading_ff;
   assign rsp_ch.quat_z  = quat_z_ff;
   assign rsp_ch.quat_w  = quat_w_ff;
   assign rsp_ch.vel_lin = vel_lin_ff;
   assign rsp_ch.vel_ang = vel_ang_ff;

   // cordic is never restarted mid-run
   a_cord_start_idle: assert property (@(posedge clock) disable iff (reset)
      cord_start |-> !cord_busy)
      else $error("cordic restarted while busy");

   // a new result only comes out of the final step of a tick
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output step");

   // one item at a time
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ch.ready)
      else $error("item taken while a previous one is in work");

   // velocity items give no result
   a_vel_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch.req_type == REQ_VELOCITY) |=> ##3 !$rose(rsp_valid_ff))
      else $error("velocity item produced a result");

endmodule

// File: sim/tb_planar_odometry_integrator.sv
// ----------------------------------------------------------------------------
// tb_planar_odometry_integrator
// self-checking bench: velocity and tick items against an in-bench pose model
// ----------------------------------------------------------------------------
// a queue of pending items feeds a clocked driver, a clocked monitor checks
// each result item against the oldest predicted pose; gains are rewritten
// between phases while the block idles, random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb_planar_odometry_integrator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 80;     // tick latency plus margin
   localparam int WATCHDOG_MAX = 20000;

   typedef struct packed {
      logic        kind;
      logic [31:0] lin;
      logic [31:0] ang;
      logic [15:0] dt;
   } odo_item_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] yaw;
      logic [15:0] qz;
      logic [15:0] qw;
      logic [31:0] vl;
      logic [31:0] va;
   } pose_type;

   typedef struct packed {
      logic [7:0]  index;
      logic [15:0] data;
   } gain_write_type;

   // atan(2^-i) in binary angle units
   localparam longint ARC_STEP [30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};

   logic clock;
   logic reset;

   poi_req_if req_ch ();
   poi_rsp_if rsp_ch ();
   poi_csr_if csr_ch ();

   planar_odometry_integrator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   odo_item_type   pending_q [$];
   gain_write_type gain_q [$];
   pose_type       pose_q [$];

   // model state
   logic [15:0] gain_lin_m, gain_ang_m;
   logic [31:0] speed_m, turn_m, x_m, y_m, yaw_m;

   int mismatches;
   int ticks_sent, vel_sent, poses_seen, gain_writes;
   int req_gap, rsp_stall;
   bit req_busy_mode, rsp_busy_mode;
   int quiet_cycles;

   // -------------------------------------------------------------------------
   // clock and reset
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // model arithmetic
   // -------------------------------------------------------------------------
   function automatic logic [31:0] clamp_q16(input longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic logic [15:0] round_q15(input longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) return 16'h7fff;
      if (r < -32768) return 16'h8000;
      return r[15:0];
   endfunction

   // sin and cos in q2.30 at a binary angle, folded into the right half plane
   task automatic rotate(input logic [31:0] angle, output longint c, output longint s);
      logic [31:0] a;
      bit          flip;
      longint      xv, yv, zv, dx, dy;
      a = angle;
      flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
      if (flip) a = a + 32'h8000_0000;
      zv = longint'($signed(a));
      xv = longint'(poi_pkg::CORDIC_X0);
      yv = 0;
      for (int i = 0; i < poi_pkg::STAGE_COUNT; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (zv >= 0) begin
            xv = xv - dx; yv = yv + dy; zv = zv - ARC_STEP[i];
         end else begin
            xv = xv + dx; yv = yv - dy; zv = zv + ARC_STEP[i];
         end
      end
      c = flip ? -xv : xv;
      s = flip ? -yv : yv;
   endtask

   task automatic integrate(input odo_item_type it);
      longint           c, s, d, qc, qs;
      longint unsigned  step;
      pose_type         p;
      if (it.kind == poi_pkg::REQ_VELOCITY) begin
         speed_m = clamp_q16((longint'($signed(it.lin)) *
                              longint'($signed(gain_lin_m))) >>> 8);
         turn_m  = clamp_q16((longint'($signed(it.ang)) *
                              longint'($signed(gain_ang_m))) >>> 8);
      end else begin
         rotate(yaw_m, c, s);
         d = (longint'($signed(speed_m)) * longint'(it.dt)) >>> 16;
         x_m = clamp_q16(longint'($signed(x_m)) + ((d * c) >>> 30));
         y_m = clamp_q16(longint'($signed(y_m)) + ((d * s) >>> 30));
         // turn rate times time, scaled to binary angle; keep the upper word
         step = longint'(longint'($signed(turn_m)) * longint'(it.dt));
         step = step * 64'd683565276;
         yaw_m = yaw_m + step[63:32];
         rotate({1'b0, yaw_m[31:1]}, qc, qs);
         p.x = x_m; p.y = y_m; p.yaw = yaw_m;
         p.qz = round_q15(qs); p.qw = round_q15(qc);
         p.vl = speed_m; p.va = turn_m;
         pose_q.push_back(p);
      end
   endtask

   // model follows every accepted gain write and item
   always @(posedge clock) begin
      if (reset) begin
         gain_lin_m <= 16'd256; gain_ang_m <= 16'd256;
         speed_m <= '0; turn_m <= '0; x_m <= '0; y_m <= '0; yaw_m <= '0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == poi_pkg::CSR_GAIN_LINEAR) gain_lin_m = csr_ch.data;
            else if (csr_ch.index == poi_pkg::CSR_GAIN_ANGULAR) gain_ang_m = csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready)
            integrate('{req_ch.req_type, req_ch.lin_speed, req_ch.ang_speed,
                        req_ch.elapsed});
      end
   end

   // -------------------------------------------------------------------------
   // item driver: gap drawn per item, with stretches of back-to-back items
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.req_type <= poi_pkg::REQ_VELOCITY;
         req_ch.lin_speed <= '0; req_ch.ang_speed <= '0; req_ch.elapsed <= '0;
         req_gap = 0;
         req_busy_mode = 1'b0;
      end else if (!(req_ch.valid && !req_ch.ready)) begin
         if (req_ch.valid) begin
            if ($urandom_range(0, 19) == 0) req_busy_mode = ~req_busy_mode;
            req_gap = req_busy_mode ? 0 : $urandom_range(0, 19);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            odo_item_type it;
            it = pending_q.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.req_type <= it.kind;
            req_ch.lin_speed <= it.lin;
            req_ch.ang_speed <= it.ang;
            req_ch.elapsed <= it.dt;
            if (it.kind == poi_pkg::REQ_TICK) ticks_sent++; else vel_sent++;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // gain write driver
   always @(posedge clock) begin
      if (reset) begin
         csr_ch.valid <= 1'b0;
         csr_ch.index <= '0;
         csr_ch.data <= '0;
      end else if (!(csr_ch.valid && !csr_ch.ready)) begin
         if (gain_q.size() > 0) begin
            gain_write_type w;
            w = gain_q.pop_front();
            csr_ch.valid <= 1'b1;
            csr_ch.index <= w.index;
            csr_ch.data <= w.data;
            gain_writes++;
         end else begin
            csr_ch.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // result monitor: stall drawn per result item, checked field by field
   // -------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch pose %0d %s: expected %h got %h",
                     poses_seen, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
         rsp_busy_mode = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            pose_type p;
            if (pose_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("result item with no tick waiting");
            end else begin
               p = pose_q.pop_front();
               check_field("pos_x", p.x, rsp_ch.pos_x);
               check_field("pos_y", p.y, rsp_ch.pos_y);
               check_field("heading", p.yaw, rsp_ch.heading);
               check_field("quat_z", {16'd0, p.qz}, {16'd0, rsp_ch.quat_z});
               check_field("quat_w", {16'd0, p.qw}, {16'd0, rsp_ch.quat_w});
               check_field("vel_lin", p.vl, rsp_ch.vel_lin);
               check_field("vel_ang", p.va, rsp_ch.vel_ang);
            end
            poses_seen++;
            if ($urandom_range(0, 19) == 0) rsp_busy_mode = ~rsp_busy_mode;
            rsp_stall = rsp_busy_mode ? 0 : $urandom_range(0, 19);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         quiet_cycles = 0;
      else if (++quiet_cycles >= WATCHDOG_MAX) begin
         $display("watchdog: no progress, %0d poses still expected", pose_q.size());
         $display("[planar_odometry_integrator] ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return 32'h7fff_ffff;
         2:       return 32'h8000_0000;
         default: return $urandom_range(0, 32'h0004_0000) ^
                         ($urandom_range(0, 1) ? 32'hffff_ffff : 32'h0);
      endcase
   endfunction

   function automatic odo_item_type pick_item();
      odo_item_type it;
      it.kind = ($urandom_range(0, 9) < 4) ? poi_pkg::REQ_VELOCITY : poi_pkg::REQ_TICK;
      it.lin = pick_word();
      it.ang = pick_word();
      it.dt = ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6553));
      return it;
   endfunction

   task automatic push_item(input logic k, input logic [31:0] l, input logic [31:0] a,
                            input logic [15:0] t);
      pending_q.push_back('{k, l, a, t});
   endtask

   // gains change only once the block has drained
   task automatic settle();
      while (pending_q.size() > 0 || req_ch.valid || pose_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_gains(input logic [15:0] gl, input logic [15:0] ga);
      settle();
      gain_q.push_back('{poi_pkg::CSR_GAIN_LINEAR, gl});
      gain_q.push_back('{poi_pkg::CSR_GAIN_ANGULAR, ga});
      while (gain_q.size() > 0 || csr_ch.valid) @(posedge clock);
   endtask

   initial begin
      logic [15:0] gains [6];
      mismatches = 0; ticks_sent = 0; vel_sent = 0; poses_seen = 0; gain_writes = 0;
      quiet_cycles = 0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // tick from rest at reset gains, then speeds at both extremes
      push_item(poi_pkg::REQ_TICK, 32'h0, 32'h0, 16'hffff);
      push_item(poi_pkg::REQ_VELOCITY, 32'h0001_0000, 32'h0001_0000, 16'h1234);
      push_item(poi_pkg::REQ_TICK, 32'hdead_beef, 32'h1234_5678, 16'h0000);
      push_item(poi_pkg::REQ_TICK, 32'h0, 32'h0, 16'hffff);
      push_item(poi_pkg::REQ_VELOCITY, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0);
      // heading wraps, position runs into saturation
      repeat (6) push_item(poi_pkg::REQ_TICK, 32'h0, 32'h0, 16'hffff);
      push_item(poi_pkg::REQ_VELOCITY, 32'h8000_0000, 32'h8000_0000, 16'hffff);
      repeat (6) push_item(poi_pkg::REQ_TICK, 32'h0, 32'h0, 16'hffff);

      // extreme gains, with writes to unused indexes that must be dropped
      set_gains(16'h7fff, 16'h8000);
      gain_q.push_back('{8'd2, 16'h0000});
      gain_q.push_back('{8'hff, 16'h1111});
      while (gain_q.size() > 0 || csr_ch.valid) @(posedge clock);
      push_item(poi_pkg::REQ_VELOCITY, 32'h7fff_ffff, 32'h8000_0000, 16'h0);
      push_item(poi_pkg::REQ_TICK, 32'h0, 32'h0, 16'h8000);
      push_item(poi_pkg::REQ_VELOCITY, 32'hffff_ffff, 32'h0000_0001, 16'h0);
      push_item(poi_pkg::REQ_TICK, 32'h0, 32'h0, 16'h0001);

      gains = '{16'h0100, 16'h8000, 16'h7fff, 16'h0000, 16'hff00, 16'h0040};
      for (int ph = 0; ph < 6; ph++) begin
         set_gains(($urandom_range(0, 1) ? gains[ph] : 16'($urandom())),
                   gains[(ph + 3) % 6] ^ 16'($urandom_range(0, 1) ? $urandom() : 0));
         repeat (290) pending_q.push_back(pick_item());
      end

      settle();
      $display("sent %0d velocity and %0d tick items, checked %0d poses",
               vel_sent, ticks_sent, poses_seen);
      $display("%0d gain writes across seven gain settings, %0d mismatches",
               gain_writes, mismatches);
      if (mismatches == 0 && pose_q.size() == 0)
         $display("[planar_odometry_integrator] OK");
      else
         $display("[planar_odometry_integrator] ERROR");
      $finish;
   end

endmodule
